// ===== hdl/tsma_pkg.sv =====
// shared constants for the temperature sensor moving average unit
package tsma_pkg;

    // adc code and result field widths
    localparam int CODE_W = 12;
    localparam int TEMP_W = 16;
    localparam int USED_W = 4;

    // code to degrees: (OFFSET_CODE - code) / 5 + BASE_DEG
    localparam int OFFSET_CODE = 1774;
    localparam int BASE_DEG = 25;

    // floor(m / 5) == (m * RECIP_DIV5) >> RECIP_SHIFT for every 12-bit m
    localparam int RECIP_DIV5 = 52429;
    localparam int RECIP_W = 16;
    localparam int RECIP_SHIFT = 18;
    localparam int QUOT5_W = 9;

    localparam int WINDOW_DEF = 8;

endpackage

// ===== hdl/temp_sensor_moving_average_unit.sv =====
// temperature sensor moving average: top level with sequencer and running sum
//
// One beat on the input channel carries a 12-bit sensor adc code in raw_code.
// The code is turned into degrees, stored in a ring of WINDOW entries, and the
// floor of the mean of the entries filled so far leaves as one output beat
// (avg_temp, with samples_used = entries averaged, masked to 4 bits).
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// An item goes through the convert, adjust and update states and then the
// bit-serial divider by the fill count before output valid rises;
// in_stall stays high for that whole time, so one item is in flight at once.
// A new input beat is taken only after the previous item has left the finish
// state and loaded the output register.
// The result sits in an output register: while out_stall holds it, the next
// input beat is still taken and that item waits at the end of its division
// until the register is free.
// Reset clears the running sum, write pointer and fill count; the ring itself
// is not cleared, since entries are read back only after being written.
module temp_sensor_moving_average_unit
    import tsma_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CODE_W-1:0] raw_code,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [TEMP_W-1:0] avg_temp,
    output logic [USED_W-1:0] samples_used
);

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = TEMP_W + $clog2(WINDOW);
    localparam int PROD_W = CODE_W + RECIP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_ADJ,
        ST_UPD,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t              state_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [QUOT5_W-1:0]  q5_reg;
    logic                neg_reg;
    logic [TEMP_W-1:0]   temp_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [PTR_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic                div_start_reg;
    logic                out_valid_reg;
    logic [TEMP_W-1:0]   avg_reg;
    logic [USED_W-1:0]   used_reg;

    logic                in_fire;
    logic                full;
    logic                out_free;
    logic signed [CODE_W:0] diff;
    logic [CODE_W-1:0]   mag;
    logic [PROD_W-1:0]   prod;
    logic [TEMP_W-1:0]   temp_next;
    logic [SUM_W-1:0]    sum_next;
    logic [TEMP_W-1:0]   old_temp;
    logic                div_done;
    logic [SUM_W-1:0]    div_quo;

    assign in_fire  = in_valid && !in_stall;
    assign full     = (fill_reg == CNT_W'(WINDOW));
    assign out_free = !out_valid_reg || !out_stall;

    // code to degrees, magnitude divided by 5 through a reciprocal multiply
    always_comb
    begin
        diff = (CODE_W + 1)'(OFFSET_CODE) - $signed({1'b0, code_reg});
        mag  = diff[CODE_W] ? CODE_W'(-diff) : diff[CODE_W-1:0];
        prod = PROD_W'(mag) * PROD_W'(RECIP_DIV5);
        temp_next = neg_reg ? TEMP_W'(BASE_DEG) - TEMP_W'(q5_reg)
                            : TEMP_W'(BASE_DEG) + TEMP_W'(q5_reg);
        sum_next = sum_reg - (full ? SUM_W'(old_temp) : '0) + SUM_W'(temp_reg);
    end

    tsma_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (state_reg == ST_UPD),
        .wr_addr (pos_reg),
        .wr_data (temp_reg),
        .rd_en   (in_fire),
        .rd_addr (pos_reg),
        .rd_data (old_temp)
    );

    tsma_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            code_reg      <= '0;
            q5_reg        <= '0;
            neg_reg       <= 1'b0;
            temp_reg      <= '0;
            sum_reg       <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            avg_reg       <= '0;
            used_reg      <= '0;
        end
        else
        begin
            // divider starts the cycle after the sum and fill count settle
            div_start_reg <= (state_reg == ST_UPD);
            // the finish state reloads the output register itself once it is free
            if (out_valid_reg && !out_stall && state_reg != ST_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        code_reg  <= raw_code;
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    q5_reg    <= prod[RECIP_SHIFT +: QUOT5_W];
                    neg_reg   <= diff[CODE_W];
                    state_reg <= ST_ADJ;
                end
                ST_ADJ:
                begin
                    temp_reg  <= temp_next;
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    sum_reg <= sum_next;
                    if (pos_reg == PTR_W'(WINDOW - 1))
                    begin
                        pos_reg  <= '0;
                        fill_reg <= CNT_W'(WINDOW);
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                        if (!full)
                        begin
                            fill_reg <= CNT_W'(pos_reg) + 1'b1;
                        end
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        avg_reg       <= div_quo[TEMP_W-1:0];
                        used_reg      <= USED_W'({{USED_W{1'b0}}, fill_reg});
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign avg_temp     = avg_reg;
    assign samples_used = used_reg;

    // fill count never passes the window
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    // during warm-up the write pointer tracks the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> (CNT_W'(pos_reg) == fill_reg))
        else $error("write pointer out of step with fill count");

    // divider finishes only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // a new result never overwrites one still held by the receiver
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && state_reg == ST_FIN) |=> (state_reg == ST_FIN))
        else $error("result loaded over a stalled beat");

endmodule

// ===== hdl/tsma_ram.sv =====
// generic single-port-write ram with registered read
module tsma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/tsma_div.sv =====
// restoring divider, one quotient bit per cycle
module tsma_div #(
    parameter int DIVIDEND_W = 19,
    parameter int DIVISOR_W = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_diff;
    logic                  fits;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    always_comb
    begin
        trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial_diff = trial - {1'b0, dvs_reg};
        fits       = (trial >= {1'b0, dvs_reg});
        rem_next   = fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_next   = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== tb/tsma_avg_monitor.sv =====
// channel monitor with running-average predictor and result compare for the unit
module tsma_avg_monitor
    import tsma_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [CODE_W-1:0] raw_code,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [TEMP_W-1:0] avg_temp,
    input  logic [USED_W-1:0] samples_used,
    output int                mismatch_count,
    output int                pending_beats
);

    localparam int DEG_STEP = 5;

    typedef struct packed {
        logic [TEMP_W-1:0] avg;
        logic [USED_W-1:0] used;
    } avg_result_t;

    avg_result_t       expected_avgs[$];
    logic [TEMP_W-1:0] temp_ring[WINDOW];
    int unsigned       ring_pos;
    int unsigned       filled;
    int unsigned       temp_sum;
    int                errors;

    function automatic avg_result_t predict_average(input logic [CODE_W-1:0] code);
        int          diff;
        int          deg;
        logic [TEMP_W-1:0] temp;
        avg_result_t res;
        diff = OFFSET_CODE - int'(code);
        // signed division truncates toward zero, then wrap to the field width
        deg = diff / DEG_STEP + BASE_DEG;
        temp = deg[TEMP_W-1:0];
        if (filled >= WINDOW)
            temp_sum -= temp_ring[ring_pos];
        temp_ring[ring_pos] = temp;
        temp_sum += temp;
        if (ring_pos == WINDOW - 1)
        begin
            ring_pos = 0;
            filled = WINDOW;
        end
        else
        begin
            ring_pos++;
            if (filled != WINDOW)
                filled = ring_pos;
        end
        res.avg = TEMP_W'(temp_sum / filled);
        res.used = USED_W'(filled);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        avg_result_t want;
        if (!rst_n)
        begin
            expected_avgs.delete();
            ring_pos = 0;
            filled = 0;
            temp_sum = 0;
            errors = 0;
            for (int i = 0; i < WINDOW; i++)
                temp_ring[i] = '0;
            mismatch_count <= 0;
            pending_beats <= 0;
        end
        else
        begin
            // result beat belongs to an earlier item, so pop before pushing
            if (out_valid && !out_stall)
            begin
                if (expected_avgs.size() == 0)
                begin
                    $display("%0t: output beat with nothing expected, avg_temp %0d samples_used %0d",
                             $time, avg_temp, samples_used);
                    errors++;
                end
                else
                begin
                    want = expected_avgs.pop_front();
                    if (avg_temp !== want.avg)
                    begin
                        $display("%0t: avg_temp expected %0d actual %0d",
                                 $time, want.avg, avg_temp);
                        errors++;
                    end
                    if (samples_used !== want.used)
                    begin
                        $display("%0t: samples_used expected %0d actual %0d",
                                 $time, want.used, samples_used);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_avgs.push_back(predict_average(raw_code));
            mismatch_count <= errors;
            pending_beats <= expected_avgs.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// stimulus, clock, reset and verdict for the temperature moving average unit
module tb;
    import tsma_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int PHASES = 3;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [CODE_W-1:0] raw_code;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [TEMP_W-1:0] avg_temp;
    logic [USED_W-1:0] samples_used;
    int                mismatch_count;
    int                pending_beats;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                cycle_count = 0;

    temp_sensor_moving_average_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_code     (raw_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .avg_temp     (avg_temp),
        .samples_used (samples_used)
    );

    tsma_avg_monitor avg_mon (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .raw_code       (raw_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .avg_temp       (avg_temp),
        .samples_used   (samples_used),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n)
            out_stall <= ($urandom_range(99) < recv_idle_pct);

    task automatic send_code(input logic [CODE_W-1:0] code);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_code <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // hold the input off until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_beats == 0);
        @(posedge clk);
    endtask

    function automatic logic [CODE_W-1:0] random_code();
        int unsigned pick;
        pick = $urandom_range(99);
        // mostly codes around the sensor operating point and the wrap boundary
        if (pick < 70)
            return CODE_W'($urandom_range(2100, 1600));
        else if (pick < 85)
            return CODE_W'($urandom_range(4095, 0));
        else
        begin
            case ($urandom_range(3))
                0: return '0;
                1: return '1;
                2: return CODE_W'(1903);
                default: return CODE_W'(1904);
            endcase
        end
    endfunction

    initial
    begin
        logic [CODE_W-1:0] directed_codes[$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        raw_code = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full ring of the largest wrapped temperature, then extremes and boundaries
        for (int i = 0; i < 8; i++)
            directed_codes.push_back(CODE_W'(1904));
        directed_codes = {directed_codes, CODE_W'(0), CODE_W'(0), CODE_W'(0),
                          CODE_W'(4095), CODE_W'(4095), CODE_W'(4095),
                          CODE_W'(1774), CODE_W'(1775), CODE_W'(1779), CODE_W'(1780),
                          CODE_W'(1903), CODE_W'(1904), CODE_W'(12'haaa),
                          CODE_W'(12'h555), CODE_W'(1)};
        foreach (directed_codes[i])
            send_code(directed_codes[i]);
        drain_results();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 48;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
                send_code(random_code());
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_beats == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tsma_pkg.sv
hdl/tsma_ram.sv
hdl/tsma_div.sv
hdl/temp_sensor_moving_average_unit.sv
tb/tsma_avg_monitor.sv
tb/tb.sv
